// File: rtl/qcqc_pkg.sv
// ----------------------------------------------------------------------------
// Quad cell quality check package
// Widths, register indexes, status codes and the angle lane beat type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qcqc_pkg;

   localparam int COORD_WIDTH = 20;
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int LEN_W = 2 * DIFF_W;
   localparam int HALF_W = LEN_W / 2;
   localparam int DSQ_W = 2 * LEN_W;
   localparam int CSQ_W = 31;
   localparam int RHS_W = CSQ_W + DSQ_W;
   localparam int ALIM_W = 24;
   localparam int AL_W = ALIM_W + LEN_W;
   localparam int COS_W = 16;

   localparam logic [2:0] REG_CROSSING_ENABLE = 3'd0;
   localparam logic [2:0] REG_ASPECT_ENABLE = 3'd1;
   localparam logic [2:0] REG_ASPECT_LIMIT_SQUARED = 3'd2;
   localparam logic [2:0] REG_ANGLE_ENABLE = 3'd3;
   localparam logic [2:0] REG_ANGLE_COS_LIMIT = 3'd4;

   localparam logic [1:0] ASPECT_OK = 2'd0;
   localparam logic [1:0] ASPECT_ZERO_EDGE = 2'd1;
   localparam logic [1:0] ASPECT_RATIO = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0] dot_mag;
      logic dot_pos;
      logic dot_zero;
      logic [LEN_W-1:0] len_k;
      logic [LEN_W-1:0] len_p;
   } lane_in_type;

endpackage

// File: rtl/qcqc_angle_lane.sv
// ----------------------------------------------------------------------------
// Quad cell quality check corner angle lane
// Five-stage pipeline that flags one corner whose cosine exceeds the limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qcqc_angle_lane (
   input logic clock,
   input qcqc_pkg::lane_in_type lane_in,
   input logic [qcqc_pkg::CSQ_W-1:0] csq,
   input logic c_neg,
   output logic flag
);

   localparam int H = qcqc_pkg::HALF_W;

   logic [2*H-1:0] dhh_ff, dhl_ff, dll_ff, phh_ff, phl_ff, plh_ff, pll_ff;
   logic [2*H-1:0] dhh_in, dhl_in, dll_in, phh_in, phl_in, plh_in, pll_in;
   logic [3:0] pos_ff, zero_ff, degen_ff;
   logic degen_in;
   logic [qcqc_pkg::DSQ_W-1:0] dsq5_ff, dsq6_ff, dsq_in, pq5_ff, pq_in;
   logic [H+qcqc_pkg::CSQ_W-1:0] r_ff [4];
   logic [H+qcqc_pkg::CSQ_W-1:0] r_in [4];
   logic [qcqc_pkg::RHS_W-1:0] lhs_ff, rhs_ff, lhs_in, rhs_in;
   logic flag_ff, flag_in;

   always_comb begin
      dhh_in = lane_in.dot_mag[2*H-1:H] * lane_in.dot_mag[2*H-1:H];
      dhl_in = lane_in.dot_mag[2*H-1:H] * lane_in.dot_mag[H-1:0];
      dll_in = lane_in.dot_mag[H-1:0] * lane_in.dot_mag[H-1:0];
      phh_in = lane_in.len_k[2*H-1:H] * lane_in.len_p[2*H-1:H];
      phl_in = lane_in.len_k[2*H-1:H] * lane_in.len_p[H-1:0];
      plh_in = lane_in.len_k[H-1:0] * lane_in.len_p[2*H-1:H];
      pll_in = lane_in.len_k[H-1:0] * lane_in.len_p[H-1:0];
      degen_in = (lane_in.len_k == '0) || (lane_in.len_p == '0);
      dsq_in = {dhh_ff, {(2*H){1'b0}}}
         + {{(H-1){1'b0}}, dhl_ff, {(H+1){1'b0}}}
         + {{(2*H){1'b0}}, dll_ff};
      pq_in = {phh_ff, {(2*H){1'b0}}}
         + {{(H-1){1'b0}}, ({1'b0, phl_ff} + {1'b0, plh_ff}), {H{1'b0}}}
         + {{(2*H){1'b0}}, pll_ff};
      for (int i = 0; i < 4; i++) begin
         r_in[i] = csq * pq5_ff[i*H +: H];
      end
      rhs_in = '0;
      for (int i = 0; i < 4; i++) begin
         rhs_in = rhs_in + (qcqc_pkg::RHS_W'(r_ff[i]) << (i * H));
      end
      lhs_in = {1'b0, dsq6_ff, {(qcqc_pkg::CSQ_W-1){1'b0}}};
      if (c_neg) begin
         flag_in = pos_ff[3] || zero_ff[3] || (lhs_ff < rhs_ff);
      end else begin
         flag_in = pos_ff[3] && (lhs_ff > rhs_ff);
      end
      flag_in = flag_in && !degen_ff[3];
   end

   always_ff @(posedge clock) begin
      dhh_ff <= dhh_in;
      dhl_ff <= dhl_in;
      dll_ff <= dll_in;
      phh_ff <= phh_in;
      phl_ff <= phl_in;
      plh_ff <= plh_in;
      pll_ff <= pll_in;
      pos_ff <= {pos_ff[2:0], lane_in.dot_pos};
      zero_ff <= {zero_ff[2:0], lane_in.dot_zero};
      degen_ff <= {degen_ff[2:0], degen_in};
      dsq5_ff <= dsq_in;
      pq5_ff <= pq_in;
      dsq6_ff <= dsq5_ff;
      r_ff <= r_in;
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
      flag_ff <= flag_in;
   end

   assign flag = flag_ff;

endmodule

// File: rtl/quad_cell_quality_check.sv
// ----------------------------------------------------------------------------
// Quad cell quality check
// Crossed-cell, edge aspect and corner angle verdicts for one cell per beat.
// ----------------------------------------------------------------------------
// The block takes one cell per clock cycle and returns its verdicts on one
// strobed cycle of rsp_valid. Busy stays low, since the result side never
// stalls. The pipeline depth is set by the corner angle lanes, which chain
// three multiplier stages and a wide compare. The user must write registers
// only while no cell is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module quad_cell_quality_check (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic signed [qcqc_pkg::COORD_WIDTH-1:0] req_corner0_x,
   input logic signed [qcqc_pkg::COORD_WIDTH-1:0] req_corner0_y,
   input logic signed [qcqc_pkg::COORD_WIDTH-1:0] req_corner1_x,
   input logic signed [qcqc_pkg::COORD_WIDTH-1:0] req_corner1_y,
   input logic signed [qcqc_pkg::COORD_WIDTH-1:0] req_corner2_x,
   input logic signed [qcqc_pkg::COORD_WIDTH-1:0] req_corner2_y,
   input logic signed [qcqc_pkg::COORD_WIDTH-1:0] req_corner3_x,
   input logic signed [qcqc_pkg::COORD_WIDTH-1:0] req_corner3_y,
   output logic rsp_valid,
   output logic rsp_crossed_flag,
   output logic [1:0] rsp_aspect_status,
   output logic [1:0] rsp_aspect_edge,
   output logic [3:0] rsp_angle_fail_mask,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [4:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   localparam int CW = qcqc_pkg::COORD_WIDTH;
   localparam int DW = qcqc_pkg::DIFF_W;
   localparam int PW = qcqc_pkg::PROD_W;
   localparam int LW = qcqc_pkg::LEN_W;
   localparam int H = qcqc_pkg::HALF_W;
   localparam int AW = qcqc_pkg::AL_W;

   logic cross_en_ff, aspect_en_ff, angle_en_ff;
   logic [qcqc_pkg::ALIM_W-1:0] alim_ff;
   logic [qcqc_pkg::COS_W-1:0] cos_ff, cmag;
   logic [31:0] csq_full;
   logic [qcqc_pkg::CSQ_W-1:0] csq_ff, csq_in;
   logic wr;
   logic accept;
   logic [9:1] vld_ff;

   logic signed [CW-1:0] cx [4];
   logic signed [CW-1:0] cy [4];
   logic signed [DW-1:0] ex_ff [4];
   logic signed [DW-1:0] ey_ff [4];
   logic signed [DW-1:0] ex_in [4];
   logic signed [DW-1:0] ey_in [4];
   logic signed [PW-1:0] sqx_ff [4];
   logic signed [PW-1:0] sqy_ff [4];
   logic signed [PW-1:0] dxx_ff [4];
   logic signed [PW-1:0] dyy_ff [4];
   logic signed [PW-1:0] cp_ff [4];
   logic signed [PW-1:0] sqx_in [4];
   logic signed [PW-1:0] sqy_in [4];
   logic signed [PW-1:0] dxx_in [4];
   logic signed [PW-1:0] dyy_in [4];
   logic signed [PW-1:0] cp_in [4];
   logic [LW-1:0] len3_ff [4];
   logic [LW-1:0] len4_ff [4];
   logic [LW-1:0] len5_ff [4];
   logic [LW-1:0] len_in [4];
   qcqc_pkg::lane_in_type lane_ff [4];
   qcqc_pkg::lane_in_type lane_in [4];
   logic signed [PW:0] dsum [4];
   logic signed [PW:0] cr1, cr2;
   logic crossed_in;
   logic [8:3] xd_ff;
   logic [H+qcqc_pkg::ALIM_W-1:0] aplo_ff [4];
   logic [H+qcqc_pkg::ALIM_W-1:0] aphi_ff [4];
   logic [H+qcqc_pkg::ALIM_W-1:0] aplo_in [4];
   logic [H+qcqc_pkg::ALIM_W-1:0] aphi_in [4];
   logic [AW-1:0] al_ff [4];
   logic [AW-1:0] al_in [4];
   logic [3:0] zero_ff, bad_ff, zero_in, bad_in;
   logic [1:0] stat7_ff, edge7_ff, stat8_ff, edge8_ff, stat_in, edge_in;
   logic found;
   logic [3:0] aflag;

   assign busy = 1'b0;
   assign csr_pready = 1'b1;
   assign accept = start && !busy;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cross_en_ff <= 1'b1;
         aspect_en_ff <= 1'b0;
         alim_ff <= 24'd147456;
         angle_en_ff <= 1'b0;
         cos_ff <= 16'd25102;
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[8:1], accept};
         if (wr) begin
            case (csr_paddr[4:2])
               qcqc_pkg::REG_CROSSING_ENABLE: begin
                  cross_en_ff <= csr_pwdata[0];
               end
               qcqc_pkg::REG_ASPECT_ENABLE: begin
                  aspect_en_ff <= csr_pwdata[0];
               end
               qcqc_pkg::REG_ASPECT_LIMIT_SQUARED: begin
                  alim_ff <= csr_pwdata[qcqc_pkg::ALIM_W-1:0];
               end
               qcqc_pkg::REG_ANGLE_ENABLE: begin
                  angle_en_ff <= csr_pwdata[0];
               end
               qcqc_pkg::REG_ANGLE_COS_LIMIT: begin
                  cos_ff <= csr_pwdata[qcqc_pkg::COS_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         qcqc_pkg::REG_CROSSING_ENABLE: csr_prdata = {31'd0, cross_en_ff};
         qcqc_pkg::REG_ASPECT_ENABLE: csr_prdata = {31'd0, aspect_en_ff};
         qcqc_pkg::REG_ASPECT_LIMIT_SQUARED: csr_prdata = {8'd0, alim_ff};
         qcqc_pkg::REG_ANGLE_ENABLE: csr_prdata = {31'd0, angle_en_ff};
         qcqc_pkg::REG_ANGLE_COS_LIMIT: csr_prdata = {16'd0, cos_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign cmag = cos_ff[qcqc_pkg::COS_W-1] ? (~cos_ff + 16'd1) : cos_ff;
   assign csq_full = cmag * cmag;
   assign csq_in = csq_full[qcqc_pkg::CSQ_W-1:0];

   assign cx[0] = req_corner0_x;
   assign cy[0] = req_corner0_y;
   assign cx[1] = req_corner1_x;
   assign cy[1] = req_corner1_y;
   assign cx[2] = req_corner2_x;
   assign cy[2] = req_corner2_y;
   assign cx[3] = req_corner3_x;
   assign cy[3] = req_corner3_y;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ex_in[k] = {cx[(k+1)&3][CW-1], cx[(k+1)&3]} - {cx[k][CW-1], cx[k]};
         ey_in[k] = {cy[(k+1)&3][CW-1], cy[(k+1)&3]} - {cy[k][CW-1], cy[k]};
         sqx_in[k] = ex_ff[k] * ex_ff[k];
         sqy_in[k] = ey_ff[k] * ey_ff[k];
         dxx_in[k] = ex_ff[k] * ex_ff[(k+3)&3];
         dyy_in[k] = ey_ff[k] * ey_ff[(k+3)&3];
      end
      cp_in[0] = ex_ff[0] * ey_ff[1];
      cp_in[1] = ex_ff[1] * ey_ff[0];
      cp_in[2] = ex_ff[2] * ey_ff[3];
      cp_in[3] = ex_ff[3] * ey_ff[2];
      for (int k = 0; k < 4; k++) begin
         len_in[k] = {1'b0, sqx_ff[k][LW-2:0]} + {1'b0, sqy_ff[k][LW-2:0]};
         dsum[k] = {dxx_ff[k][PW-1], dxx_ff[k]} + {dyy_ff[k][PW-1], dyy_ff[k]};
      end
      for (int k = 0; k < 4; k++) begin
         lane_in[k].dot_mag = dsum[k][PW] ? LW'(-dsum[k]) : dsum[k][LW-1:0];
         lane_in[k].dot_pos = dsum[k][PW];
         lane_in[k].dot_zero = (dsum[k] == '0);
         lane_in[k].len_k = len_in[k];
         lane_in[k].len_p = len_in[(k+3)&3];
      end
      cr1 = {cp_ff[0][PW-1], cp_ff[0]} - {cp_ff[1][PW-1], cp_ff[1]};
      cr2 = {cp_ff[2][PW-1], cp_ff[2]} - {cp_ff[3][PW-1], cp_ff[3]};
      crossed_in = ((cr1 > 0) && (cr2 < 0)) || ((cr1 < 0) && (cr2 > 0));
      for (int k = 0; k < 4; k++) begin
         aplo_in[k] = alim_ff * len3_ff[k][H-1:0];
         aphi_in[k] = alim_ff * len3_ff[k][LW-1:H];
         al_in[k] = {aphi_ff[k], {H{1'b0}}} + AW'(aplo_ff[k]);
      end
      for (int k = 0; k < 4; k++) begin
         zero_in[k] = (len5_ff[k] == '0);
         bad_in[k] = (AW'({len5_ff[(k+1)&3], 16'd0}) > al_ff[k])
            || (al_ff[(k+1)&3] < AW'({len5_ff[k], 16'd0}));
      end
      stat_in = qcqc_pkg::ASPECT_OK;
      edge_in = 2'd0;
      found = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (!found && zero_ff[k]) begin
            stat_in = qcqc_pkg::ASPECT_ZERO_EDGE;
            edge_in = 2'(k);
            found = 1'b1;
         end else if (!found && bad_ff[k]) begin
            stat_in = qcqc_pkg::ASPECT_RATIO;
            edge_in = 2'(k);
            found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      csq_ff <= csq_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      dxx_ff <= dxx_in;
      dyy_ff <= dyy_in;
      cp_ff <= cp_in;
      len3_ff <= len_in;
      lane_ff <= lane_in;
      xd_ff <= {xd_ff[7:3], crossed_in};
      aplo_ff <= aplo_in;
      aphi_ff <= aphi_in;
      len4_ff <= len3_ff;
      al_ff <= al_in;
      len5_ff <= len4_ff;
      zero_ff <= zero_in;
      bad_ff <= bad_in;
      stat7_ff <= stat_in;
      edge7_ff <= edge_in;
      stat8_ff <= stat7_ff;
      edge8_ff <= edge7_ff;
      rsp_crossed_flag <= cross_en_ff && xd_ff[8];
      rsp_aspect_status <= aspect_en_ff ? stat8_ff : qcqc_pkg::ASPECT_OK;
      rsp_aspect_edge <= aspect_en_ff ? edge8_ff : 2'd0;
      rsp_angle_fail_mask <= angle_en_ff ? aflag : 4'd0;
   end

   for (genvar k = 0; k < 4; k++) begin : g_lane
      qcqc_angle_lane u_lane (
         .clock(clock),
         .lane_in(lane_ff[k]),
         .csq(csq_ff),
         .c_neg(cos_ff[qcqc_pkg::COS_W-1]),
         .flag(aflag[k])
      );
   end

   assign rsp_valid = vld_ff[9];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##9 rsp_valid) else $error("result beat missing");
   a_edge_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_aspect_status == qcqc_pkg::ASPECT_OK) |-> rsp_aspect_edge == 2'd0)
      else $error("edge index without aspect failure");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_aspect_status != 2'd3) else $error("bad aspect status");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy while delivering");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Quad cell quality check testbench
// Sends cells through the command port under several register settings and
// idle patterns. An exact integer predictor computes the crossed flag, aspect
// walk and corner angle mask for each cell. A monitor checks every strobed
// result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int CW = qcqc_pkg::COORD_WIDTH;
   localparam int DRAIN_CYCLES = 16;
   localparam int FIFO_DEPTH = 2048;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [7:0][CW-1:0] cell_type;

   typedef struct packed {
      logic crossed;
      logic [1:0] astat;
      logic [1:0] aedge;
      logic [3:0] amask;
   } verdict_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   coord_type corner [8];
   logic rsp_valid;
   logic rsp_crossed_flag;
   logic [1:0] rsp_aspect_status;
   logic [1:0] rsp_aspect_edge;
   logic [3:0] rsp_angle_fail_mask;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [4:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   logic cfg_cross_en;
   logic cfg_aspect_en;
   logic [23:0] cfg_aspect_lim;
   logic cfg_angle_en;
   logic signed [15:0] cfg_cos_lim;

   verdict_type expected_fifo [FIFO_DEPTH];
   int exp_wr = 0;
   int exp_rd = 0;
   int mismatches = 0;
   int cells_sent = 0;
   int verdicts_seen = 0;
   int sender_idle_pct = 0;

   initial begin
      for (int i = 0; i < 8; i++) corner[i] = '0;
   end

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   quad_cell_quality_check uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_corner0_x(corner[0]), .req_corner0_y(corner[1]),
      .req_corner1_x(corner[2]), .req_corner1_y(corner[3]),
      .req_corner2_x(corner[4]), .req_corner2_y(corner[5]),
      .req_corner3_x(corner[6]), .req_corner3_y(corner[7]),
      .rsp_valid(rsp_valid), .rsp_crossed_flag(rsp_crossed_flag),
      .rsp_aspect_status(rsp_aspect_status), .rsp_aspect_edge(rsp_aspect_edge),
      .rsp_angle_fail_mask(rsp_angle_fail_mask),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   function automatic int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic verdict_type grade_cell(cell_type c);
      verdict_type r;
      longint x [4], y [4], ex [4], ey [4];
      logic [127:0] len [4];
      logic [127:0] nxt, a, lhs, rhs, csq, dmag;
      longint dot, s1, s2;
      int p;
      bit flag;
      r = '0;
      for (int k = 0; k < 4; k++) begin
         x[k] = longint'($signed(c[2*k]));
         y[k] = longint'($signed(c[2*k+1]));
      end
      for (int k = 0; k < 4; k++) begin
         ex[k] = x[(k+1)&3] - x[k];
         ey[k] = y[(k+1)&3] - y[k];
         len[k] = 128'(ex[k] * ex[k]) + 128'(ey[k] * ey[k]);
      end
      if (cfg_cross_en) begin
         s1 = (x[2]-x[1])*(y[0]-y[1]) - (y[2]-y[1])*(x[0]-x[1]);
         s2 = (x[0]-x[3])*(y[2]-y[3]) - (y[0]-y[3])*(x[2]-x[3]);
         r.crossed = (sign_of(s1) * sign_of(s2) < 0);
      end
      if (cfg_aspect_en) begin
         a = 128'(cfg_aspect_lim);
         for (int k = 0; k < 4; k++) begin
            nxt = len[(k+1)&3];
            if (len[k] == 0) begin
               r.astat = qcqc_pkg::ASPECT_ZERO_EDGE;
               r.aedge = k[1:0];
               break;
            end
            if (nxt * 65536 > a * len[k] || nxt * a < len[k] * 65536) begin
               r.astat = qcqc_pkg::ASPECT_RATIO;
               r.aedge = k[1:0];
               break;
            end
         end
      end
      if (cfg_angle_en) begin
         csq = 128'(longint'(cfg_cos_lim) * longint'(cfg_cos_lim));
         for (int k = 0; k < 4; k++) begin
            p = (k + 3) & 3;
            if (len[k] == 0 || len[p] == 0) continue;
            dot = -(ex[k] * ex[p]) - (ey[k] * ey[p]);
            dmag = 128'(dot < 0 ? -dot : dot);
            lhs = (dmag * dmag) << 30;
            rhs = csq * len[k] * len[p];
            if (cfg_cos_lim < 0) flag = (dot >= 0) || (lhs < rhs);
            else flag = (dot > 0) && (lhs > rhs);
            r.amask[k] = flag;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_crossed_flag, rsp_aspect_status, rsp_aspect_edge,
                rsp_angle_fail_mask};
         verdicts_seen++;
         if (exp_wr == exp_rd) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat: %p", got);
         end else begin
            want = expected_fifo[exp_rd % FIFO_DEPTH];
            exp_rd++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Verdict mismatch: expected crossed %0d stat %0d edge %0d mask %h,",
                           want.crossed, want.astat, want.aedge, want.amask);
                  $display("   got crossed %0d stat %0d edge %0d mask %h",
                           got.crossed, got.astat, got.aedge, got.amask);
               end
            end
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      case (idx)
         qcqc_pkg::REG_CROSSING_ENABLE: cfg_cross_en = value[0];
         qcqc_pkg::REG_ASPECT_ENABLE: cfg_aspect_en = value[0];
         qcqc_pkg::REG_ASPECT_LIMIT_SQUARED: cfg_aspect_lim = value[23:0];
         qcqc_pkg::REG_ANGLE_ENABLE: cfg_angle_en = value[0];
         qcqc_pkg::REG_ANGLE_COS_LIMIT: cfg_cos_lim = value[15:0];
         default: ;
      endcase
   endtask

   task automatic csr_read_check(logic [2:0] idx, logic [31:0] want, logic [31:0] mask);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 0;
      csr_paddr = {idx, 2'b00};
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) !== (want & mask)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Register %0d read: expected %h, got %h", idx, want & mask,
                     csr_prdata & mask);
      end
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
   endtask

   task automatic set_config(bit ce, bit ae, logic [23:0] alim, bit ge,
                             logic signed [15:0] cl);
      csr_write(qcqc_pkg::REG_CROSSING_ENABLE, 32'(ce));
      csr_write(qcqc_pkg::REG_ASPECT_ENABLE, 32'(ae));
      csr_write(qcqc_pkg::REG_ASPECT_LIMIT_SQUARED, 32'(alim));
      csr_write(qcqc_pkg::REG_ANGLE_ENABLE, 32'(ge));
      csr_write(qcqc_pkg::REG_ANGLE_COS_LIMIT, 32'($unsigned(cl)));
   endtask

   // Called at a falling edge; returns at a falling edge with start still high.
   task automatic send_cell(cell_type c);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         start = 0;
         @(negedge clock);
      end
      for (int i = 0; i < 8; i++) corner[i] = c[i];
      start = 1;
      do @(posedge clock); while (busy);
      expected_fifo[exp_wr % FIFO_DEPTH] = grade_cell(c);
      exp_wr++;
      cells_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      int guard;
      start = 0;
      guard = 0;
      while (exp_wr != exp_rd && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic cell_type make_cell(coord_type x0, coord_type y0, coord_type x1,
                                          coord_type y1, coord_type x2, coord_type y2,
                                          coord_type x3, coord_type y3);
      cell_type c;
      c[0] = x0; c[1] = y0; c[2] = x1; c[3] = y1;
      c[4] = x2; c[5] = y2; c[6] = x3; c[7] = y3;
      return c;
   endfunction

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   function automatic cell_type random_cell();
      cell_type c;
      int kind, span, cx, cy, dup;
      kind = $urandom_range(99);
      if (kind < 15) begin
         for (int i = 0; i < 8; i++) c[i] = rand_coord();
      end else begin
         span = (kind < 60) ? $urandom_range(1, 64) : $urandom_range(1, 200000);
         cx = $urandom_range(0, 600000) - 300000;
         cy = $urandom_range(0, 600000) - 300000;
         c = make_cell(coord_type'(cx), coord_type'(cy), coord_type'(cx + span),
                       coord_type'(cy), coord_type'(cx + span), coord_type'(cy + span),
                       coord_type'(cx), coord_type'(cy + span));
         for (int i = 0; i < 8; i++)
            c[i] = c[i] + coord_type'($urandom_range(0, span) - span / 2);
         if (kind >= 90) begin
            dup = $urandom_range(3);
            c[2*((dup+1)&3)] = c[2*dup];
            c[2*((dup+1)&3)+1] = c[2*dup+1];
         end else if (kind >= 85) begin
            {c[4], c[6]} = {c[6], c[4]};
            {c[5], c[7]} = {c[7], c[5]};
         end
      end
      return c;
   endfunction

   task automatic test_register_reset;
      csr_read_check(qcqc_pkg::REG_CROSSING_ENABLE, 32'd1, 32'h1);
      csr_read_check(qcqc_pkg::REG_ASPECT_ENABLE, 32'd0, 32'h1);
      csr_read_check(qcqc_pkg::REG_ASPECT_LIMIT_SQUARED, 32'd147456, 32'hFFFFFF);
      csr_read_check(qcqc_pkg::REG_ANGLE_ENABLE, 32'd0, 32'h1);
      csr_read_check(qcqc_pkg::REG_ANGLE_COS_LIMIT, 32'd25102, 32'hFFFF);
   endtask

   task automatic test_directed_cells;
      coord_type lo, hi;
      lo = coord_type'(-524288);
      hi = coord_type'(524287);
      @(negedge clock);
      send_cell(make_cell(0, 0, 10, 0, 10, 10, 0, 10));
      send_cell(make_cell(0, 0, 10, 10, 10, 0, 0, 10));
      send_cell(make_cell(5, 5, 5, 5, 5, 5, 5, 5));
      send_cell(make_cell(0, 0, 0, 0, 10, 10, 0, 10));
      send_cell(make_cell(0, 0, 10, 0, 10, 0, 0, 10));
      send_cell(make_cell(0, 0, 10, 0, 10, 10, 10, 10));
      send_cell(make_cell(lo, lo, hi, lo, hi, hi, lo, hi));
      send_cell(make_cell(hi, hi, lo, hi, lo, lo, hi, lo));
      send_cell(make_cell(lo, lo, hi, hi, lo, hi, hi, lo));
      send_cell(make_cell(lo, hi, lo, hi, hi, lo, hi, lo));
      send_cell(make_cell(0, 0, 100, 0, 101, 1, 0, 1));
      send_cell(make_cell(0, 0, 15, 0, 15, 10, 0, 10));
      send_cell(make_cell(0, 0, 16, 0, 16, 10, 0, 10));
      send_cell(make_cell(0, 0, 1000, 0, 1, 10, 0, 1000));
      send_cell(make_cell(0, 0, 10, 0, 0, 10, -10, 0));
      send_cell(make_cell(0, 0, -1, 0, 0, 0, 1, 1));
      send_cell(make_cell(hi, lo, lo, hi, hi, lo, lo, hi));
      drain();
   endtask

   task automatic test_random_cells(int count, int idle_pct);
      sender_idle_pct = idle_pct;
      @(negedge clock);
      for (int n = 0; n < count; n++) send_cell(random_cell());
      drain();
   endtask

   initial begin
      cfg_cross_en = 1;
      cfg_aspect_en = 0;
      cfg_aspect_lim = 24'd147456;
      cfg_angle_en = 0;
      cfg_cos_lim = 16'sd25102;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_register_reset();
      test_directed_cells();
      set_config(1, 1, 24'd147456, 1, 16'sd25102);
      test_directed_cells();
      set_config(1, 1, 24'd0, 1, 16'sh8000);
      test_directed_cells();
      set_config(0, 1, 24'd65536, 1, 16'sd32767);
      test_directed_cells();
      set_config(1, 1, 24'hFFFFFF, 1, 16'sd0);
      test_directed_cells();
      set_config(1, 1, 24'd147456, 1, 16'sd25102);
      test_random_cells(300, 0);
      set_config(1, 1, 24'd262144, 1, -16'sd16384);
      test_random_cells(300, 64);
      set_config(0, 1, 24'd70000, 1, 16'sd30000);
      test_random_cells(200, 0);
      set_config(1, 1, 24'd30000, 1, 16'sd5000);
      test_random_cells(200, 15);
      set_config(1, 0, 24'd147456, 0, 16'sd25102);
      test_random_cells(100, 64);
      $display("Sent %0d cells and checked %0d verdicts in ten register phases,",
               cells_sent, verdicts_seen);
      $display("covering directed shapes and random cells with and without sender gaps.");
      if (mismatches == 0 && exp_wr == exp_rd) begin
         $display("All tests passed");
      end else begin
         $display("Mismatches: %0d, results still expected: %0d", mismatches,
                  exp_wr - exp_rd);
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout waiting for results.");
      $display("Some tests failed");
      $finish;
   end

endmodule
